@@ hw/rtl/binomial_coefficient_unit_macros.svh @@
// Assertion macros shared by the binomial coefficient unit
`ifndef BINOMIAL_COEFFICIENT_UNIT_MACROS_SVH
`define BINOMIAL_COEFFICIENT_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BCU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcu: assertion failed");

// next-cycle implication
`define BCU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcu: assertion failed");

`endif

@@ hw/rtl/bcu_pkg.sv @@
// Types and constants of the binomial coefficient unit
package bcu_pkg;

  localparam int MAX_SET_SIZE = 64;
  localparam int NUM_CELLS    = MAX_SET_SIZE + 1;
  localparam int SET_W        = 7;
  localparam int COEF_W       = 61;
  localparam int CELL_W       = 64;
  localparam int REM_W        = $clog2(MAX_SET_SIZE + 1);

  typedef logic [SET_W-1:0]  field_t;
  typedef logic [REM_W-1:0]  rem_t;
  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  // control from the sequencer to the cell row
  typedef struct packed {
    logic load;     // seed the row for a new word
    logic step;     // one Pascal pass
    logic capture;  // move the last cell into the output register
  } ctrl_t;

endpackage

@@ hw/rtl/bcu_cell.sv @@
// One cell of the Pascal row: holds one entry, adds its left neighbor per pass
module bcu_cell (
  input  logic            clk_i,
  input  bcu_pkg::ctrl_t  ctrl_i,
  input  logic            seed_i,
  input  bcu_pkg::cell_t  left_i,
  output bcu_pkg::cell_t  value_o
);

  bcu_pkg::cell_t value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load) begin
      value_d = bcu_pkg::cell_t'(seed_i);
    end else if (ctrl_i.step) begin
      value_d = value_q + left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ hw/rtl/bcu_row.sv @@
// Row of Pascal cells; the result always lands in the last cell
module bcu_row (
  input  logic            clk_i,
  input  bcu_pkg::ctrl_t  ctrl_i,
  input  bcu_pkg::field_t choose_count_i,
  output bcu_pkg::cell_t  last_o
);

  bcu_pkg::cell_t value [bcu_pkg::NUM_CELLS];

  // The 1 is seeded at cell MAX_SET_SIZE-k, so after n passes the last cell
  // holds C(n,k). A choose count above MAX_SET_SIZE seeds nothing: result 0.
  for (genvar j = 0; j < bcu_pkg::NUM_CELLS; j++) begin : g_cell
    logic           seed;
    bcu_pkg::cell_t left;

    assign seed = (choose_count_i == bcu_pkg::field_t'(bcu_pkg::MAX_SET_SIZE - j));
    if (j == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = value[j-1];
    end

    bcu_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .seed_i  (seed),
      .left_i  (left),
      .value_o (value[j])
    );
  end

  assign last_o = value[bcu_pkg::NUM_CELLS-1];

endmodule

@@ hw/rtl/bcu_ctrl.sv @@
// Sequencer: accepts a word, runs the passes, hands off to the output register
`include "binomial_coefficient_unit_macros.svh"

module bcu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bcu_pkg::field_t set_size_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bcu_pkg::ctrl_t  ctrl_o
);

  bcu_pkg::state_e state_q, state_d;
  bcu_pkg::rem_t   remain_q, remain_d;
  logic            out_valid_q, out_valid_d;
  bcu_pkg::rem_t   n_sat;

  assign n_sat = (set_size_i > bcu_pkg::field_t'(bcu_pkg::MAX_SET_SIZE))
               ? bcu_pkg::rem_t'(bcu_pkg::MAX_SET_SIZE)
               : bcu_pkg::rem_t'(set_size_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcu_pkg::ST_IDLE;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    remain_d   = remain_q;
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      bcu_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          remain_d    = n_sat;
          state_d     = bcu_pkg::ST_RUN;
        end
      end
      bcu_pkg::ST_RUN: begin
        if (remain_q != '0) begin
          ctrl_o.step = 1'b1;
          remain_d    = remain_q - bcu_pkg::rem_t'(1);
        end else if (!out_valid_q || !out_stall_i) begin
          // output register free or being emptied this cycle
          ctrl_o.capture = 1'b1;
          state_d        = bcu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bcu_pkg::ST_IDLE;
      end
    endcase
    out_valid_d = ctrl_o.capture | (out_valid_q & out_stall_i);
  end

  assign out_valid_o = out_valid_q;

  `BCU_ASSERT_NXT(a_load_runs, ctrl_o.load, state_q == bcu_pkg::ST_RUN)
  `BCU_ASSERT_NXT(a_step_counts, ctrl_o.step, remain_q == $past(remain_q) - bcu_pkg::rem_t'(1))
  `BCU_ASSERT_IMP(a_capture_done, ctrl_o.capture, remain_q == '0 && !(out_valid_q && out_stall_i))
  `BCU_ASSERT_NXT(a_capture_shows, ctrl_o.capture, out_valid_o)

endmodule

@@ hw/rtl/binomial_coefficient_unit.sv @@
// Top level of the binomial coefficient unit
// Usage:
//   Input channel: set_size_i and choose_count_i with in_valid_i; a word is
//   taken at a clock edge where in_valid_i is high and in_stall_o is low.
//   Output channel: coefficient_o with out_valid_o; the word is taken at an
//   edge where out_valid_o is high and out_stall_i is low.
//   Result is C(n,k) with n saturated to 64; k above n gives 0.
// Timing:
//   One word at a time. The row of 65 cells is seeded as the word is accepted,
//   then runs one Pascal pass per cycle, n passes in all, then the last cell
//   is copied into the output register; a new word can be taken as soon as
//   the result shows.
// Reset: rst_ni (async, active low) returns the sequencer to idle and clears
//   out_valid_o; cell contents are not reset and are reseeded per word.
// Stall: a full output register holds its word while out_stall_i is high;
//   a finished word waits in the row until the register frees, and the input
//   side stays stalled meanwhile. A new word is accepted while the previous
//   result still waits in the output register.
module binomial_coefficient_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bcu_pkg::SET_W-1:0]   set_size_i,
  input  logic [bcu_pkg::SET_W-1:0]   choose_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bcu_pkg::COEF_W-1:0]  coefficient_o
);

  bcu_pkg::ctrl_t              ctrl;
  bcu_pkg::cell_t              last;
  logic [bcu_pkg::COEF_W-1:0]  coefficient_q, coefficient_d;

  bcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .set_size_i  (set_size_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  bcu_row u_row (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .choose_count_i (choose_count_i),
    .last_o         (last)
  );

  assign coefficient_d = ctrl.capture ? last[bcu_pkg::COEF_W-1:0] : coefficient_q;

  always_ff @(posedge clk_i) begin
    coefficient_q <= coefficient_d;
  end

  assign coefficient_o = coefficient_q;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the binomial coefficient unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIZE_CAP = bcu_pkg::MAX_SET_SIZE;
  localparam int FW       = bcu_pkg::SET_W;
  localparam int CW       = bcu_pkg::COEF_W;
  localparam int RUN_WORDS = 1850;

  typedef struct {
    logic [FW-1:0] n;
    logic [FW-1:0] k;
    logic [CW-1:0] coef;
  } choose_rec_t;

  class coef_ledger;
    choose_rec_t pending_coefs[$];
    int unsigned mismatches = 0;
    int unsigned coefs_seen = 0;

    // row of Pascal's triangle built in place, high index first, 64-bit wrap
    function logic [CW-1:0] pascal_choose(int unsigned n, int unsigned k);
      logic [63:0] row [0:SIZE_CAP];
      int unsigned top;
      if (n > SIZE_CAP) n = SIZE_CAP;
      if (k > n) return '0;
      foreach (row[i]) row[i] = '0;
      row[0] = 64'd1;
      for (int unsigned pass = 1; pass <= n; pass++) begin
        top = (pass < k) ? pass : k;
        for (int unsigned j = top; j > 0; j--) row[j] = row[j] + row[j-1];
      end
      return row[k][CW-1:0];
    endfunction

    function void note_word(logic [FW-1:0] n, logic [FW-1:0] k);
      choose_rec_t rec;
      rec.n = n;
      rec.k = k;
      rec.coef = pascal_choose(n, k);
      pending_coefs.push_back(rec);
    endfunction

    function void check_word(logic [CW-1:0] coef);
      choose_rec_t rec;
      coefs_seen++;
      if (pending_coefs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: coefficient %0d with no word outstanding", coef);
        return;
      end
      rec = pending_coefs.pop_front();
      if (coef !== rec.coef) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: C(%0d,%0d) expected %0d got %0d", rec.n, rec.k, rec.coef, coef);
      end
    endfunction

    function int unsigned pending();
      return pending_coefs.size();
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [FW-1:0] set_size_i = '0;
  logic [FW-1:0] choose_count_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [CW-1:0] coefficient_o;

  coef_ledger ledger = new();
  bit          calm = 1'b0;  // no idling on either side while set
  int unsigned words_sent = 0;
  int unsigned words_over = 0;
  int unsigned words_sat  = 0;

  binomial_coefficient_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .set_size_i     (set_size_i),
    .choose_count_i (choose_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .coefficient_o  (coefficient_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && !calm && ($urandom_range(99) < 13);
  end

  // handshake signals are settled at the falling edge; the word moves at the next rise
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) ledger.check_word(coefficient_o);
  end

  task automatic send_word(logic [FW-1:0] n, logic [FW-1:0] k);
    bit taken;
    while (!calm && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    set_size_i     <= n;
    choose_count_i <= k;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    ledger.note_word(n, k);
    words_sent++;
    if (n > SIZE_CAP) words_sat++;
    if (k > ((n > SIZE_CAP) ? SIZE_CAP : n)) words_over++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (ledger.pending() != 0);
  endtask

  task automatic send_random_word();
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    pick = $urandom_range(99);
    if (pick < 60) begin
      n = $urandom_range(SIZE_CAP);
      k = $urandom_range(n);
    end else if (pick < 75) begin
      n = $urandom_range(SIZE_CAP);
      k = $urandom_range(127, n + 1);
    end else if (pick < 90) begin
      n = $urandom_range(127);
      k = $urandom_range(127);
    end else begin
      n = $urandom_range(127, SIZE_CAP + 1);
      k = $urandom_range(SIZE_CAP);
    end
    send_word(n[FW-1:0], k[FW-1:0]);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edges of both fields, empty set, saturated size, choose above size
    send_word(7'd0, 7'd0);
    send_word(7'd0, 7'd1);
    send_word(7'd0, 7'd127);
    send_word(7'd1, 7'd0);
    send_word(7'd1, 7'd1);
    send_word(7'd1, 7'd2);
    send_word(7'd5, 7'd2);
    send_word(7'd63, 7'd31);
    send_word(7'd64, 7'd0);
    send_word(7'd64, 7'd1);
    send_word(7'd64, 7'd32);
    send_word(7'd64, 7'd63);
    send_word(7'd64, 7'd64);
    send_word(7'd64, 7'd65);
    send_word(7'd64, 7'd127);
    send_word(7'd65, 7'd33);
    send_word(7'd100, 7'd50);
    send_word(7'd127, 7'd0);
    send_word(7'd127, 7'd32);
    send_word(7'd127, 7'd64);
    send_word(7'd127, 7'd65);
    send_word(7'd127, 7'd127);
    drain_results();

    for (int i = 0; i < RUN_WORDS; i++) begin
      calm = (i >= 700 && i < 1000);
      send_random_word();
      if (i % 400 == 399) drain_results();
    end
    calm = 1'b0;

    drain_results();
    repeat (70) @(posedge clk_i);
    if (ledger.pending() != 0) begin
      ledger.mismatches++;
      $display("tb: %0d coefficients never arrived", ledger.pending());
    end
    $display("tb: %0d words sent, %0d coefficients checked", words_sent, ledger.coefs_seen);
    $display("tb: %0d chose more than the set held, %0d had set size saturated",
             words_over, words_sat);
    if (ledger.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", ledger.mismatches);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bcu_pkg.sv
hw/rtl/bcu_cell.sv
hw/rtl/bcu_row.sv
hw/rtl/bcu_ctrl.sv
hw/rtl/binomial_coefficient_unit.sv
tb/sv/tb.sv
